/* hdl/edrs_pkg.sv */
// Package for the elevator disk request scheduler: status codes and
// the stored request record. No dependencies.
`timescale 1ns / 1ps
package edrs_pkg;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    localparam logic ACT_INSERT   = 1'b0;
    localparam logic ACT_SCHEDULE = 1'b1;

    localparam logic [7:0] RESET_CYLINDER = 8'd12;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] cyl;
        logic [4:0] track;
        logic [2:0] sector;
    } req_t;

    localparam int REQ_W = $bits(req_t);

endpackage

/* hdl/elevator_disk_request_scheduler.sv */
// Top level of the elevator (SCAN) disk request scheduler.
// Depends on edrs_pkg and edrs_ram.
`timescale 1ns / 1ps
// Requests enter when start is high and busy is low; every request gives
// one result, shown for a single cycle with done high. A schedule walks
// the pending table through one read port and one compare unit: one pass
// over the N pending entries and a closing state, a second pass when no
// entry sits on the head cylinder, a third when the arm reverses, then a
// fetch of the chosen entry and a compaction sweep that shifts later
// entries down one slot, with a read and a write per entry. Results cannot
// be stalled. No clearing pass after reset.
module elevator_disk_request_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [7:0]           request_id,
    input  logic [7:0]           request_cylinder,
    input  logic [4:0]           request_track,
    input  logic [2:0]           request_sector,
    output logic                 done,
    output logic [1:0]           status,
    output logic [7:0]           served_id,
    output logic [7:0]           served_cylinder,
    output logic [4:0]           served_track,
    output logic [2:0]           served_sector,
    output logic                 moving_down,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] pending_count
);
    import edrs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_SCAN, S_SCAN_END, S_FETCH, S_FETCH_WAIT, S_SHIFT_RD,
        S_SHIFT_WR, S_DONE
    } state_t;

    // Search passes: same cylinder, ahead, reverse extreme
    typedef enum logic [1:0] {
        P_SAME, P_AHEAD, P_EXTREME
    } pass_t;

    state_t          state_reg;
    pass_t           pass_reg;
    logic [CW-1:0]   count_reg;
    logic [7:0]      head_cyl_reg;
    logic [2:0]      head_sec_reg;
    logic            arm_down_reg;
    logic [CW-1:0]   rd_idx_reg;   // address issued
    logic [CW-1:0]   cmp_idx_reg;  // index of data now on rdata
    logic            cmp_vld_reg;
    logic            found_reg;
    logic [AW-1:0]   best_reg;
    logic [7:0]      best_key_reg;
    req_t            chosen_reg;
    logic [CW-1:0]   sh_idx_reg;

    logic            done_reg;
    status_t         status_reg;
    req_t            out_reg;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [REQ_W-1:0] wdata;
    logic [AW-1:0]   raddr;
    logic [REQ_W-1:0] rdata;
    req_t            rd_req;

    assign rd_req = req_t'(rdata);

    edrs_ram #(.WIDTH(REQ_W), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Shared compare unit: key and candidate test for the current pass
    logic [7:0] key;
    logic       cand;
    logic       better;
    logic [2:0] sdist;
    always_comb
    begin
        sdist  = (rd_req.sector >= head_sec_reg) ? rd_req.sector - head_sec_reg
                                                 : head_sec_reg - rd_req.sector;
        key    = rd_req.cyl;
        cand   = 1'b1;
        better = 1'b0;
        case (pass_reg)
            P_SAME:
            begin
                key    = {5'd0, sdist};
                cand   = (rd_req.cyl == head_cyl_reg);
                better = key < best_key_reg;
            end
            P_AHEAD:
            begin
                cand   = arm_down_reg ? (rd_req.cyl < head_cyl_reg)
                                      : (rd_req.cyl > head_cyl_reg);
                better = arm_down_reg ? (key > best_key_reg) : (key < best_key_reg);
            end
            default:
            begin
                better = arm_down_reg ? (key > best_key_reg) : (key < best_key_reg);
            end
        endcase
    end

    // Table port muxing
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = {request_id, request_cylinder, request_track, request_sector};
        raddr = rd_idx_reg[AW-1:0];
        if (state_reg == S_IDLE && start && action == ACT_INSERT
            && count_reg < CW'(TABLE_DEPTH))
        begin
            we = 1'b1;
        end
        else if (state_reg == S_SHIFT_WR)
        begin
            we    = 1'b1;
            waddr = sh_idx_reg[AW-1:0];
            wdata = rdata;
        end
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= P_SAME;
            count_reg    <= '0;
            head_cyl_reg <= RESET_CYLINDER;
            head_sec_reg <= 3'd0;
            arm_down_reg <= 1'b0;
            rd_idx_reg   <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_key_reg <= '0;
            chosen_reg   <= '0;
            sh_idx_reg   <= '0;
            done_reg     <= 1'b0;
            status_reg   <= ST_INSERTED;
            out_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        out_reg <= '0;
                        if (action == ACT_INSERT)
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                count_reg  <= count_reg + 1'b1;
                                status_reg <= ST_INSERTED;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                            end
                            state_reg <= S_INS;
                        end
                        else if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_INS;
                        end
                        else
                        begin
                            pass_reg    <= P_SAME;
                            rd_idx_reg  <= '0;
                            cmp_vld_reg <= 1'b0;
                            found_reg   <= 1'b0;
                            state_reg   <= S_SCAN;
                        end
                    end
                end
                S_INS:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // Issue next read, compare the word returned
                    cmp_idx_reg <= rd_idx_reg;
                    cmp_vld_reg <= (rd_idx_reg < count_reg);
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (cmp_vld_reg && cand && (!found_reg || better))
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= cmp_idx_reg[AW-1:0];
                        best_key_reg <= key;
                    end
                    if (!(rd_idx_reg < count_reg) && !cmp_vld_reg)
                    begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END:
                begin
                    rd_idx_reg  <= '0;
                    cmp_vld_reg <= 1'b0;
                    if (found_reg)
                    begin
                        rd_idx_reg <= CW'(best_reg);
                        state_reg  <= S_FETCH;
                    end
                    else
                    begin
                        if (pass_reg == P_SAME)
                        begin
                            pass_reg <= P_AHEAD;
                        end
                        else
                        begin
                            pass_reg     <= P_EXTREME;
                            arm_down_reg <= ~arm_down_reg;
                        end
                        state_reg <= S_SCAN;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_FETCH_WAIT;
                end
                S_FETCH_WAIT:
                begin
                    chosen_reg <= rd_req;
                    sh_idx_reg <= CW'(best_reg);
                    rd_idx_reg <= CW'(best_reg) + 1'b1;
                    state_reg  <= S_SHIFT_RD;
                end
                S_SHIFT_RD:
                begin
                    // Pull the next later entry down one slot
                    if (sh_idx_reg + 1'b1 < count_reg)
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SHIFT_WR:
                begin
                    sh_idx_reg <= sh_idx_reg + 1'b1;
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    state_reg  <= S_SHIFT_RD;
                end
                S_DONE:
                begin
                    count_reg    <= count_reg - 1'b1;
                    head_cyl_reg <= chosen_reg.cyl;
                    head_sec_reg <= chosen_reg.sector;
                    out_reg      <= chosen_reg;
                    status_reg   <= ST_SERVED;
                    state_reg    <= S_INS;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign served_id       = out_reg.id;
    assign served_cylinder = out_reg.cyl;
    assign served_track    = out_reg.track;
    assign served_sector   = out_reg.sector;
    assign moving_down     = arm_down_reg;
    assign pending_count   = count_reg;

`ifndef SYNTH
    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without work");
    // Count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("count overflow");
    // A served request shrinks the table by one (count drops in S_DONE, before done is raised in S_INS)
    a_served_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_SERVED) |-> count_reg == $past(count_reg, 2) - 1'b1)
        else $error("served without removal");
`endif
endmodule

/* hdl/edrs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module edrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* tb/sv/testbench.sv */
// Testbench for the elevator disk request scheduler: directed table, then random
// insert/schedule traffic checked against an in-bench scheduler model.
// Depends on edrs_pkg and elevator_disk_request_scheduler.
`timescale 1ns / 1ps
module testbench;
    import edrs_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_REQUESTS = 1850;

    typedef struct {
        status_t    st;
        logic [7:0] id;
        logic [7:0] cyl;
        logic [4:0] track;
        logic [2:0] sector;
        logic       down;
        logic [4:0] count;
    } outcome_t;

    typedef struct {
        logic       act;
        logic [7:0] id;
        logic [7:0] cyl;
        logic [4:0] track;
        logic [2:0] sector;
        logic       typed;   // expected status typed in below
        status_t    st;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = ACT_INSERT;
    logic [7:0] request_id = '0;
    logic [7:0] request_cylinder = '0;
    logic [4:0] request_track = '0;
    logic [2:0] request_sector = '0;
    logic busy, done, moving_down;
    logic [1:0] status;
    logic [7:0] served_id, served_cylinder;
    logic [4:0] served_track;
    logic [2:0] served_sector;
    logic [4:0] pending_count;

    // scheduler model state
    req_t       table_q[$];
    logic [7:0] head_cyl;
    logic [2:0] head_sec;
    logic       arm_dn;

    outcome_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    row_t rows[$];

    elevator_disk_request_scheduler #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    // Apply one request to the model and return its outcome.
    function automatic outcome_t schedule_model(input logic act, input req_t r);
        outcome_t o;
        int best, bestd, d;
        bit found;
        req_t ch;
        o = '{ST_INSERTED, 8'd0, 8'd0, 5'd0, 3'd0, 1'b0, 5'd0};
        found = 1'b0;
        best = 0;
        bestd = 0;
        if (act == ACT_INSERT) begin
            if (table_q.size() >= DEPTH) o.st = ST_FULL;
            else table_q.push_back(r);
        end else if (table_q.size() == 0) begin
            o.st = ST_EMPTY;
        end else begin
            foreach (table_q[i])
                if (table_q[i].cyl == head_cyl) begin
                    d = int'(table_q[i].sector) - int'(head_sec);
                    if (d < 0) d = -d;
                    if (!found || d < bestd) begin
                        best = i;
                        bestd = d;
                        found = 1'b1;
                    end
                end
            if (!found && !arm_dn) begin
                foreach (table_q[i])
                    if (table_q[i].cyl > head_cyl && (!found || table_q[i].cyl < table_q[best].cyl))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                if (!found) begin
                    arm_dn = 1'b1;
                    foreach (table_q[i])
                        if (table_q[i].cyl > table_q[best].cyl) best = i;
                end
            end else if (!found) begin
                foreach (table_q[i])
                    if (table_q[i].cyl < head_cyl && (!found || table_q[i].cyl > table_q[best].cyl))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                if (!found) begin
                    arm_dn = 1'b0;
                    foreach (table_q[i])
                        if (table_q[i].cyl < table_q[best].cyl) best = i;
                end
            end
            ch = table_q[best];
            table_q.delete(best);
            head_cyl = ch.cyl;
            head_sec = ch.sector;
            o.st = ST_SERVED;
            o.id = ch.id;
            o.cyl = ch.cyl;
            o.track = ch.track;
            o.sector = ch.sector;
        end
        o.down = arm_dn;
        o.count = 5'(table_q.size());
        return o;
    endfunction

    // Drive one request and wait until it is taken.
    task automatic send(input logic act, input logic [7:0] id, input logic [7:0] cyl,
                        input logic [4:0] trk, input logic [2:0] sec, input bit typed,
                        input status_t want);
        outcome_t o;
        req_t r;
        action <= act;
        request_id <= id;
        request_cylinder <= cyl;
        request_track <= trk;
        request_sector <= sec;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = '{id, cyl, trk, sec};
        o = schedule_model(act, r);
        if (typed && o.st != want) report("typed status", o.st, want);
        expected_q.push_back(o);
        @(negedge clk);
    endtask

    // Check each result against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = expected_q.pop_front();
                if (status != e.st) report("status", status, e.st);
                if (served_id != e.id) report("served_id", served_id, e.id);
                if (served_cylinder != e.cyl) report("served_cylinder", served_cylinder, e.cyl);
                if (served_track != e.track) report("served_track", served_track, e.track);
                if (served_sector != e.sector) report("served_sector", served_sector, e.sector);
                if (moving_down != e.down) report("moving_down", moving_down, e.down);
                if (pending_count != e.count) report("pending_count", pending_count, e.count);
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic row_t mk(input logic act, input int id, input int cyl, input int trk,
                                input int sec, input bit typed, input status_t st);
        mk = '{act, 8'(id), 8'(cyl), 5'(trk), 3'(sec), typed, st};
    endfunction

    initial
    begin
        int burst, n, mode;
        logic act;
        head_cyl = RESET_CYLINDER;
        head_sec = 3'd0;
        arm_dn = 1'b0;
        // empty, head cylinder, up/down reversal, extremes, ties, full table
        rows.push_back(mk(ACT_SCHEDULE, 0, 0, 0, 0, 1, ST_EMPTY));
        rows.push_back(mk(ACT_INSERT, 255, 12, 19, 7, 1, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 1, 12, 0, 2, 0, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 2, 0, 31, 0, 0, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 3, 255, 5, 3, 0, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 4, 199, 5, 3, 0, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 5, 199, 6, 4, 0, ST_INSERTED));
        for (int i = 0; i < 7; i++) rows.push_back(mk(ACT_SCHEDULE, 0, 0, 0, 0, 0, ST_SERVED));
        for (int i = 0; i < 16; i++)
            rows.push_back(mk(ACT_INSERT, 16 + i, 40 + 3 * i, i, i, 1, ST_INSERTED));
        rows.push_back(mk(ACT_INSERT, 99, 1, 1, 1, 1, ST_FULL));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send(rows[i].act, rows[i].id, rows[i].cyl, rows[i].track, rows[i].sector,
                 rows[i].typed, rows[i].st);
        start <= 1'b0;

        // hold off until every expected result has come
        while (expected_q.size() != 0) @(negedge clk);

        n = 0;
        while (n < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 30);
            mode = $urandom_range(0, 3);
            for (int b = 0; b < burst; b++) begin
                // insert-heavy, schedule-heavy or balanced phases
                act = ($urandom_range(0, 9) < (mode == 0 ? 7 : mode == 1 ? 3 : 5)) ?
                      ACT_INSERT : ACT_SCHEDULE;
                send(act, 8'($urandom), 8'((mode == 3) ? $urandom_range(0, 255) :
                     $urandom_range(0, 1) ? 32'(head_cyl) : $urandom_range(0, 199)),
                     5'($urandom), 3'($urandom), 0, ST_INSERTED);
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
